// ===== src/spadd_pkg.sv =====
// Shared types and constants for the sparse polynomial add/merge block.
package spadd_pkg;

	// Field widths of the request and result words.
	localparam int COEF_W = 16;
	localparam int EXP_W = 8;
	localparam int SUM_W = 17;
	localparam int REQ_W = 2;

	// Request codes as they arrive on the input port.
	localparam logic [REQ_W-1:0] REQ_LOAD_FIRST = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LOAD_SECOND = 2'd1;
	localparam logic [REQ_W-1:0] REQ_START = 2'd2;

	// Depth of the command queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	// Classified command kinds carried through the queue.
	typedef enum logic [1:0] {
		CMD_LOAD_FIRST = 2'd0,
		CMD_LOAD_SECOND = 2'd1,
		CMD_START = 2'd2
	} cmd_kind_t;

	// One classified command word.
	typedef struct packed {
		cmd_kind_t kind;
		logic signed [COEF_W-1:0] coef;
		logic [EXP_W-1:0] expo;
	} cmd_t;

endpackage

// ===== src/spadd_front.sv =====
// Front end: accepts request words, drops unused codes and classifies the rest.
module spadd_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [spadd_pkg::REQ_W-1:0] req_type,
	input logic signed [spadd_pkg::COEF_W-1:0] term_coefficient,
	input logic [spadd_pkg::EXP_W-1:0] term_exponent,
	output logic push_valid,
	input logic push_ready,
	output spadd_pkg::cmd_t push_cmd
);

	logic cmd_valid_s1;
	spadd_pkg::cmd_t cmd_s1;
	spadd_pkg::cmd_t cmd_class;
	logic cmd_known;
	logic in_fire;

	// The stage frees up when empty or when its word moves into the queue.
	assign in_ready = !cmd_valid_s1 || push_ready;
	assign in_fire = in_valid && in_ready;
	assign push_valid = cmd_valid_s1;
	assign push_cmd = cmd_s1;

	// Map the request code onto a command kind; the unused code is dropped.
	always_comb begin
		cmd_class.coef = term_coefficient;
		cmd_class.expo = term_exponent;
		cmd_class.kind = spadd_pkg::CMD_START;
		cmd_known = 1'b1;
		unique case (req_type)
			spadd_pkg::REQ_LOAD_FIRST: cmd_class.kind = spadd_pkg::CMD_LOAD_FIRST;
			spadd_pkg::REQ_LOAD_SECOND: cmd_class.kind = spadd_pkg::CMD_LOAD_SECOND;
			spadd_pkg::REQ_START: cmd_class.kind = spadd_pkg::CMD_START;
			default: cmd_known = 1'b0;
		endcase
	end

	// Valid bit of the classify stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (in_fire) begin
			cmd_valid_s1 <= cmd_known;
		end else if (push_ready) begin
			cmd_valid_s1 <= 1'b0;
		end
	end

	// Payload of the classify stage.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1 <= cmd_class;
		end
	end

endmodule

// ===== src/spadd_queue.sv =====
// Short command queue that decouples the front end from the merge engine.
module spadd_queue (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input spadd_pkg::cmd_t push_cmd,
	output logic pop_valid,
	input logic pop_ready,
	output spadd_pkg::cmd_t pop_cmd
);

	localparam int PTR_W = $clog2(spadd_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(spadd_pkg::QUEUE_DEPTH + 1);

	spadd_pkg::cmd_t mem_q [spadd_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic push_fire;
	logic pop_fire;

	assign push_ready = cnt_q != CNT_W'(spadd_pkg::QUEUE_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_cmd = mem_q[rd_ptr_q];
	assign push_fire = push_valid && push_ready;
	assign pop_fire = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop_fire) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push_fire && !pop_fire) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop_fire && !push_fire) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== src/spadd_back.sv =====
// Back end: holds both term lists and runs the merge, one result word per cycle while out_ready does not stall it.
module spadd_back #(
	parameter int MAX_TERMS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input spadd_pkg::cmd_t q_cmd,
	output logic q_pop,
	output logic out_valid,
	input logic out_ready,
	output logic signed [spadd_pkg::SUM_W-1:0] sum_coefficient,
	output logic [spadd_pkg::EXP_W-1:0] sum_exponent,
	output logic last_term,
	output logic empty_result,
	output logic terms_dropped
);

	localparam int CNT_W = $clog2(MAX_TERMS + 1);
	localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

	typedef enum logic {
		ST_IDLE,
		ST_MERGE
	} state_t;

	state_t state_q;

	logic signed [spadd_pkg::COEF_W-1:0] first_coef_q [MAX_TERMS];
	logic [spadd_pkg::EXP_W-1:0] first_exp_q [MAX_TERMS];
	logic signed [spadd_pkg::COEF_W-1:0] second_coef_q [MAX_TERMS];
	logic [spadd_pkg::EXP_W-1:0] second_exp_q [MAX_TERMS];
	logic [CNT_W-1:0] first_cnt_q;
	logic [CNT_W-1:0] second_cnt_q;
	logic drop_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;

	logic out_valid_q;
	logic signed [spadd_pkg::SUM_W-1:0] coef_q;
	logic [spadd_pkg::EXP_W-1:0] exp_q;
	logic last_q;
	logic empty_q;
	logic dropped_q;

	logic slot_free;
	logic out_load;
	logic first_room;
	logic second_room;
	logic first_we;
	logic second_we;
	logic a_ok;
	logic b_ok;
	logic take_a;
	logic take_b;
	logic signed [spadd_pkg::COEF_W-1:0] a_coef;
	logic signed [spadd_pkg::COEF_W-1:0] b_coef;
	logic [spadd_pkg::EXP_W-1:0] a_exp;
	logic [spadd_pkg::EXP_W-1:0] b_exp;
	logic signed [spadd_pkg::SUM_W-1:0] sel_coef;
	logic [spadd_pkg::EXP_W-1:0] sel_exp;
	logic [CNT_W-1:0] i_nxt;
	logic [CNT_W-1:0] j_nxt;
	logic merge_last;

	assign out_valid = out_valid_q;
	assign sum_coefficient = coef_q;
	assign sum_exponent = exp_q;
	assign last_term = last_q;
	assign empty_result = empty_q;
	assign terms_dropped = dropped_q;

	// The output register can take a word when empty or being drained.
	assign slot_free = !out_valid_q || out_ready;

	// A command leaves the queue only in idle; a start also needs the output slot.
	assign q_pop = (state_q == ST_IDLE) && q_valid &&
		((q_cmd.kind != spadd_pkg::CMD_START) || slot_free);

	// A new word enters the output register on a merge step or an empty start.
	assign out_load = ((state_q == ST_MERGE) && slot_free) ||
		(q_pop && (q_cmd.kind == spadd_pkg::CMD_START) &&
		(first_cnt_q == '0) && (second_cnt_q == '0));

	assign first_room = first_cnt_q < CNT_W'(MAX_TERMS);
	assign second_room = second_cnt_q < CNT_W'(MAX_TERMS);
	assign first_we = q_pop && (q_cmd.kind == spadd_pkg::CMD_LOAD_FIRST) && first_room;
	assign second_we = q_pop && (q_cmd.kind == spadd_pkg::CMD_LOAD_SECOND) && second_room;

	// Head terms of both lists.
	assign a_coef = first_coef_q[i_q[IDX_W-1:0]];
	assign a_exp = first_exp_q[i_q[IDX_W-1:0]];
	assign b_coef = second_coef_q[j_q[IDX_W-1:0]];
	assign b_exp = second_exp_q[j_q[IDX_W-1:0]];

	// Merge step: equal exponents add, otherwise the higher exponent goes first,
	// and once one list is exhausted the other one is copied out.
	always_comb begin
		a_ok = i_q < first_cnt_q;
		b_ok = j_q < second_cnt_q;
		take_a = 1'b0;
		take_b = 1'b0;
		if (a_ok && b_ok && (a_exp == b_exp)) begin
			take_a = 1'b1;
			take_b = 1'b1;
		end else if (a_ok && (!b_ok || (a_exp > b_exp))) begin
			take_a = 1'b1;
		end else begin
			take_b = 1'b1;
		end
		sel_coef = (take_a ? spadd_pkg::SUM_W'(a_coef) : '0) +
			(take_b ? spadd_pkg::SUM_W'(b_coef) : '0);
		sel_exp = take_a ? a_exp : b_exp;
		i_nxt = i_q + CNT_W'(take_a);
		j_nxt = j_q + CNT_W'(take_b);
		merge_last = (i_nxt == first_cnt_q) && (j_nxt == second_cnt_q);
	end

	// Term list storage; entries beyond the counts are never read.
	always_ff @(posedge clk) begin
		if (first_we) begin
			first_coef_q[first_cnt_q[IDX_W-1:0]] <= q_cmd.coef;
			first_exp_q[first_cnt_q[IDX_W-1:0]] <= q_cmd.expo;
		end
		if (second_we) begin
			second_coef_q[second_cnt_q[IDX_W-1:0]] <= q_cmd.coef;
			second_exp_q[second_cnt_q[IDX_W-1:0]] <= q_cmd.expo;
		end
	end

	// Sequencer, list counts, drop flag and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			first_cnt_q <= '0;
			second_cnt_q <= '0;
			drop_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			out_valid_q <= 1'b0;
			coef_q <= '0;
			exp_q <= '0;
			last_q <= 1'b0;
			empty_q <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						unique case (q_cmd.kind)
							spadd_pkg::CMD_LOAD_FIRST: begin
								if (first_room) begin
									first_cnt_q <= first_cnt_q + CNT_W'(1);
								end else begin
									drop_q <= 1'b1;
								end
							end
							spadd_pkg::CMD_LOAD_SECOND: begin
								if (second_room) begin
									second_cnt_q <= second_cnt_q + CNT_W'(1);
								end else begin
									drop_q <= 1'b1;
								end
							end
							spadd_pkg::CMD_START: begin
								if ((first_cnt_q == '0) && (second_cnt_q == '0)) begin
									// Both lists empty: a single flagged word.
									coef_q <= '0;
									exp_q <= '0;
									last_q <= 1'b1;
									empty_q <= 1'b1;
									dropped_q <= drop_q;
									drop_q <= 1'b0;
								end else begin
									i_q <= '0;
									j_q <= '0;
									state_q <= ST_MERGE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_MERGE: begin
					if (slot_free) begin
						coef_q <= sel_coef;
						exp_q <= sel_exp;
						last_q <= merge_last;
						empty_q <= 1'b0;
						dropped_q <= drop_q;
						i_q <= i_nxt;
						j_q <= j_nxt;
						if (merge_last) begin
							first_cnt_q <= '0;
							second_cnt_q <= '0;
							drop_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// While merging, at least one list still has terms left.
	a_merge_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> ((i_q < first_cnt_q) || (j_q < second_cnt_q)))
		else $error("merge running with both lists exhausted");

	// No queued command is taken while a merge is in progress.
	a_no_pop_merge: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> !q_pop)
		else $error("queue popped during merge");

	// An empty-result word is always the last word of its merge.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && empty_q) |-> last_q)
		else $error("empty result not marked last");

	// Emitting the last term returns to idle with both lists cleared.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_MERGE) && slot_free && merge_last) |=>
		((state_q == ST_IDLE) && (first_cnt_q == '0) && (second_cnt_q == '0) && !drop_q))
		else $error("lists not cleared after merge");
`endif

endmodule

// ===== src/sparse_polynomial_add_merge_core.sv =====
// Top level of the sparse polynomial add/merge block.
//
//   channel | direction | handshake           | fields
//   in      | to block  | in_valid/in_ready   | req_type, term_coefficient, term_exponent
//   out     | from blk  | out_valid/out_ready | sum_coefficient, sum_exponent, last_term,
//           |           |                     | empty_result, terms_dropped
//
// Loads are taken one per cycle while the path has room and reach the lists through the
// classify register and a four-word command queue.
// A start with terms gives n result words (at most 2*MAX_TERMS) from the merge engine,
// one comparator/adder step per word; an empty start gives a single flagged word.
// The input keeps accepting during a merge until the command queue fills.
// Reset clears the list counts, the drop flag, the queue and all valid bits;
// list contents are not cleared. A stall on out_ready holds the merge in place.
module sparse_polynomial_add_merge_core #(
	parameter int MAX_TERMS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] req_type,
	input logic signed [15:0] term_coefficient,
	input logic [7:0] term_exponent,
	output logic out_valid,
	input logic out_ready,
	output logic signed [16:0] sum_coefficient,
	output logic [7:0] sum_exponent,
	output logic last_term,
	output logic empty_result,
	output logic terms_dropped
);

	logic push_valid;
	logic push_ready;
	spadd_pkg::cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	spadd_pkg::cmd_t pop_cmd;

	// Accept and classify request words.
	spadd_front u_front (
		.clk (clk),
		.arst_n (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.term_coefficient (term_coefficient),
		.term_exponent (term_exponent),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd (push_cmd)
	);

	// Command queue between the two halves.
	spadd_queue u_queue (
		.clk (clk),
		.arst_n (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd (push_cmd),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd (pop_cmd)
	);

	// Term lists and merge engine.
	spadd_back #(
		.MAX_TERMS (MAX_TERMS)
	) u_back (
		.clk (clk),
		.arst_n (arst_n),
		.q_valid (pop_valid),
		.q_cmd (pop_cmd),
		.q_pop (pop_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sum_coefficient (sum_coefficient),
		.sum_exponent (sum_exponent),
		.last_term (last_term),
		.empty_result (empty_result),
		.terms_dropped (terms_dropped)
	);

endmodule
